### hw/rtl/bdl_pkg.sv
// shared types and constants for the button debounce and long press unit
`timescale 1ns / 1ps

package bdl_pkg;

  // buttons that carry a long-press mask bit
  localparam int MASK_BITS = 4;
  localparam int BTN_W     = 2;
  localparam int TIME_W    = 32;
  localparam int DEB_W     = 20;
  localparam int LONG_W    = 24;
  localparam int CFG_W     = 24;
  localparam int IDX_W     = 2;

  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 8;

  // depth of the queue between front and back
  localparam int QDEPTH    = 2;
  localparam int QCNT_W    = $clog2(QDEPTH + 1);
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [DEB_W-1:0]     DEBOUNCE_RST  = 20'd25000;
  localparam logic [LONG_W-1:0]    LONG_PRESS_RST = 24'd700000;
  localparam logic [MASK_BITS-1:0] LONG_MASK_RST = 4'd4;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_LONG_PRESS = 2'd1;
  localparam logic [IDX_W-1:0] REG_LONG_MASK  = 2'd2;

  // all events caused by one input item
  typedef struct packed {
    logic [MASK_BITS-1:0] longs;
    logic                 short_v;
    logic [BTN_W-1:0]     short_btn;
  } evt_rec_t;

endpackage

### hw/rtl/bdl_front.sv
// front end: config registers, per-button state, long-press and debounce classification
`timescale 1ns / 1ps

module bdl_front import bdl_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // button[1:0], pressed[2], time_us[34:3]
  input  logic [0:0]           s_axis_tuser,  // req_type
  output logic                 q_push,
  output evt_rec_t             q_rec,
  input  logic                 q_full
);

  // only buttons that an edge can address hold state
  localparam int NB = (NUM_BUTTONS < MASK_BITS) ? NUM_BUTTONS : MASK_BITS;

  logic [DEB_W-1:0]     deb_limit;
  logic [LONG_W-1:0]    hold_limit;
  logic [MASK_BITS-1:0] long_mask;

  logic [NB-1:0]     held, held_next;
  logic [NB-1:0]     long_done, long_done_next;
  logic [TIME_W-1:0] press_time [NB];
  logic [TIME_W-1:0] press_time_next [NB];
  logic [TIME_W-1:0] last_edge_time [NB];
  logic [TIME_W-1:0] last_edge_time_next [NB];

  logic              accept;
  logic              edge_ok;
  logic [NB-1:0]     fire;
  logic              short_v;
  logic [BTN_W-1:0]  btn;
  logic              press;
  logic [TIME_W-1:0] now;

  assign btn   = s_axis_tdata[BTN_W-1:0];
  assign press = s_axis_tdata[BTN_W];
  assign now   = s_axis_tdata[BTN_W+TIME_W:BTN_W+1];

  assign s_axis_tready = !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign edge_ok       = !s_axis_tuser[0] && (32'(btn) < NUM_BUTTONS);

  always_comb begin
    fire                = '0;
    short_v             = 1'b0;
    held_next           = held;
    long_done_next      = long_done;
    press_time_next     = press_time;
    last_edge_time_next = last_edge_time;
    // long-press scan first, all lanes in parallel
    for (int i = 0; i < NB; i++) begin
      if (long_mask[i] && held[i] && !long_done[i] &&
          (32'(now - press_time[i]) >= {8'b0, hold_limit})) begin
        fire[i]           = 1'b1;
        long_done_next[i] = 1'b1;
      end
    end
    // then the edge on its own button
    for (int i = 0; i < NB; i++) begin
      if (edge_ok && btn == BTN_W'(i) &&
          (32'(now - last_edge_time[i]) >= {12'b0, deb_limit})) begin
        last_edge_time_next[i] = now;
        if (press) begin
          if (!held[i]) begin
            held_next[i]       = 1'b1;
            long_done_next[i]  = 1'b0;
            press_time_next[i] = now;
            short_v            = !long_mask[i];
          end
        end else if (held[i]) begin
          held_next[i] = 1'b0;
          short_v      = long_mask[i] && !long_done_next[i];
        end
      end
    end
  end

  assign q_rec.longs     = MASK_BITS'(fire);
  assign q_rec.short_v   = short_v;
  assign q_rec.short_btn = btn;
  assign q_push          = accept && ((|fire) || short_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      deb_limit  <= DEBOUNCE_RST;
      hold_limit <= LONG_PRESS_RST;
      long_mask  <= LONG_MASK_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_DEBOUNCE:   deb_limit  <= cfg_data[DEB_W-1:0];
        REG_LONG_PRESS: hold_limit <= cfg_data[LONG_W-1:0];
        REG_LONG_MASK:  long_mask  <= cfg_data[MASK_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      long_done <= '0;
      for (int i = 0; i < NB; i++) begin
        press_time[i]     <= '0;
        last_edge_time[i] <= '0;
      end
    end else if (accept) begin
      held           <= held_next;
      long_done      <= long_done_next;
      press_time     <= press_time_next;
      last_edge_time <= last_edge_time_next;
    end
  end

  // a button that has fired stays marked until it is pressed again
  a_done_needs_press: assert property (@(posedge clk) disable iff (rst)
    accept && (|fire) |=> (|long_done))
    else $error("long event fired but no done flag set");

  a_short_on_edge: assert property (@(posedge clk) disable iff (rst)
    q_push && q_rec.short_v |-> !s_axis_tuser[0])
    else $error("short event from a tick item");

endmodule

### hw/rtl/bdl_fifo.sv
// small queue of event records between front and back
`timescale 1ns / 1ps

module bdl_fifo import bdl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  evt_rec_t wr_rec,
  output logic     full,
  input  logic     pop,
  output evt_rec_t rd_rec,
  output logic     empty
);

  evt_rec_t          mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full   = (count == QCNT_W'(QDEPTH));
  assign empty  = (count == '0);
  assign rd_rec = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("pop from empty queue");

endmodule

### hw/rtl/bdl_back.sv
// back end: plays out one event per cycle from each queued record while m_axis_tready is high
`timescale 1ns / 1ps

module bdl_back import bdl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  evt_rec_t             q_rec,
  input  logic                 q_empty,
  output logic                 q_pop,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // event_button[1:0], is_long[2]
  output logic                 m_axis_tlast
);

  evt_rec_t             rec;
  logic                 busy;
  logic [MASK_BITS-1:0] longs_rest;
  logic [BTN_W-1:0]     lo_idx;
  logic [BTN_W-1:0]     ev_btn;
  logic                 ev_long;
  logic                 ev_last;
  logic                 advance;
  logic                 done;

  always_comb begin
    longs_rest = rec.longs & (rec.longs - 1'b1);
    lo_idx     = '0;
    // lowest set bit wins
    for (int i = MASK_BITS - 1; i >= 0; i--) begin
      if (rec.longs[i]) begin
        lo_idx = BTN_W'(i);
      end
    end
    if (rec.longs != '0) begin
      ev_btn  = lo_idx;
      ev_long = 1'b1;
      ev_last = (longs_rest == '0) && !rec.short_v;
    end else begin
      ev_btn  = rec.short_btn;
      ev_long = 1'b0;
      ev_last = 1'b1;
    end
  end

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {{(M_TDATA_W - BTN_W - 1){1'b0}}, ev_long, ev_btn};
  assign m_axis_tlast  = ev_last;

  assign advance = m_axis_tvalid && m_axis_tready;
  assign done    = advance && ev_last;
  assign q_pop   = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (q_pop) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rec <= q_rec;
    end else if (advance) begin
      rec.longs <= longs_rest;
    end
  end

  a_busy_has_event: assert property (@(posedge clk) disable iff (rst)
    busy |-> (rec.longs != '0) || rec.short_v)
    else $error("active record holds no event");

  a_record_continues: assert property (@(posedge clk) disable iff (rst)
    advance && !ev_last |=> busy)
    else $error("record dropped before its last event");

endmodule

### hw/rtl/button_debounce_long_press_unit.sv
// top level of the button debounce and long press unit
// an item's events pass the event queue, then the back end's record register
// throughput: one input item per cycle while the two-entry event queue has room;
// the back end sends one event per cycle while m_axis_tready is high
// items that cause no event never enter the queue
// reset (rst, synchronous): config to defaults, button state cleared, queue emptied
`timescale 1ns / 1ps

module button_debounce_long_press_unit import bdl_pkg::*; #(
  parameter int NUM_BUTTONS = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // button[1:0], pressed[2], time_us[34:3]
  input  logic [0:0]           s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // event_button[1:0], is_long[2]
  output logic                 m_axis_tlast
);

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  evt_rec_t wr_rec;
  evt_rec_t rd_rec;

  bdl_front #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_push        (q_push),
    .q_rec         (wr_rec),
    .q_full        (q_full)
  );

  bdl_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (wr_rec),
    .full   (q_full),
    .pop    (q_pop),
    .rd_rec (rd_rec),
    .empty  (q_empty)
  );

  bdl_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_rec         (rd_rec),
    .q_empty       (q_empty),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

### tb/button_debounce_long_press_unit_tb.sv
// testbench for the button debounce and long press unit
`timescale 1ns / 1ps

module button_debounce_long_press_unit_tb;
  import bdl_pkg::*;

  localparam int NBTN        = 4;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYC   = 4;
  // register index with no register behind it
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum logic {REQ_EDGE = 1'b0, REQ_TICK = 1'b1} req_kind_t;

  typedef struct {
    req_kind_t         kind;
    logic [BTN_W-1:0]  btn;
    logic              press;
    logic [TIME_W-1:0] stamp;
  } btn_req_t;

  typedef struct {
    logic [BTN_W-1:0] btn;
    logic             is_long;
    logic             last;
  } btn_event_t;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_wr_en     = 1'b0;
  logic [IDX_W-1:0]     cfg_index     = '0;
  logic [CFG_W-1:0]     cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // button[1:0], pressed[2], time_us[34:3]
  logic [0:0]           s_axis_tuser  = '0;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;        // event_button[1:0], is_long[2]
  logic                 m_axis_tlast;

  // shadow copy of the registers and the per-button state
  logic [DEB_W-1:0]     deb_us       = DEBOUNCE_RST;
  logic [LONG_W-1:0]    hold_us      = LONG_PRESS_RST;
  logic [MASK_BITS-1:0] long_capable = LONG_MASK_RST;
  logic                 held       [NBTN];
  logic                 long_sent  [NBTN];
  logic [TIME_W-1:0]    press_at   [NBTN];
  logic [TIME_W-1:0]    edge_at    [NBTN];

  btn_req_t          button_reqs[$];
  btn_event_t        due_events[$];
  btn_req_t          cur_req;
  logic              in_taken = 1'b0;
  logic              no_stall = 1'b0;
  logic [TIME_W-1:0] now_us   = '0;
  int                fails    = 0;
  int                quiet_cycles = 0;

  button_debounce_long_press_unit uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // long events in button order first, then at most one short event
  task automatic predict_events(input btn_req_t r);
    btn_event_t        evs[$];
    btn_event_t        ev;
    logic [TIME_W-1:0] dt;
    int                i;
    for (i = 0; i < NBTN; i++) begin
      if (long_capable[i] && held[i] && !long_sent[i]) begin
        dt = r.stamp - press_at[i];
        if (dt >= TIME_W'(hold_us)) begin
          long_sent[i] = 1'b1;
          ev.btn = BTN_W'(i);
          ev.is_long = 1'b1;
          ev.last = 1'b0;
          evs.push_back(ev);
        end
      end
    end
    if (r.kind == REQ_EDGE) begin
      dt = r.stamp - edge_at[r.btn];
      if (dt >= TIME_W'(deb_us)) begin
        edge_at[r.btn] = r.stamp;
        ev.btn = r.btn;
        ev.is_long = 1'b0;
        ev.last = 1'b0;
        if (r.press && !held[r.btn]) begin
          held[r.btn] = 1'b1;
          long_sent[r.btn] = 1'b0;
          press_at[r.btn] = r.stamp;
          if (!long_capable[r.btn]) evs.push_back(ev);
        end else if (!r.press && held[r.btn]) begin
          held[r.btn] = 1'b0;
          if (long_capable[r.btn] && !long_sent[r.btn]) evs.push_back(ev);
        end
      end
    end
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[k]) due_events.push_back(evs[k]);
  endtask

  task automatic queue_req(input req_kind_t kind, input logic [BTN_W-1:0] btn,
                           input logic press, input logic [TIME_W-1:0] stamp);
    btn_req_t r;
    r.kind = kind;
    r.btn = btn;
    r.press = press;
    r.stamp = stamp;
    button_reqs.push_back(r);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_DEBOUNCE:   deb_us = val[DEB_W-1:0];
      REG_LONG_PRESS: hold_us = val[LONG_W-1:0];
      REG_LONG_MASK:  long_capable = val[MASK_BITS-1:0];
      default: ;
    endcase
  endtask

  // upper bits beyond each register's width carry junk
  task automatic set_config(input logic [DEB_W-1:0] deb, input logic [LONG_W-1:0] hold,
                            input logic [MASK_BITS-1:0] mask);
    write_reg(REG_DEBOUNCE, {4'($urandom), deb});
    write_reg(REG_SPARE, CFG_W'($urandom));
    write_reg(REG_LONG_PRESS, hold);
    write_reg(REG_LONG_MASK, {20'($urandom), mask});
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    while (button_reqs.size() != 0 || s_axis_tvalid || due_events.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [TIME_W-1:0] bounce_gap();
    if (deb_us == '0) return '0;
    if ($urandom_range(0, 3) == 0) return TIME_W'(deb_us) - 1;
    return TIME_W'($urandom_range(0, deb_us - 1));
  endfunction

  function automatic logic [TIME_W-1:0] settle_gap();
    if ($urandom_range(0, 3) == 0) return TIME_W'(deb_us);
    return TIME_W'(deb_us) + TIME_W'($urandom_range(1, 5000));
  endfunction

  // press a few buttons with some bounce, tick around the hold threshold, release; or queue a random stray item
  task automatic queue_gestures(input int count);
    logic [BTN_W-1:0]  picks[$];
    logic [BTN_W-1:0]  b;
    logic [TIME_W-1:0] pressed_at;
    int                added;
    int                nb;
    int                k;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 99) < 20) begin
        if ($urandom_range(0, 1) == 1) now_us = $urandom;
        else now_us += bounce_gap();
        queue_req(req_kind_t'($urandom_range(0, 1)), BTN_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), now_us);
        added++;
      end else begin
        picks.delete();
        nb = $urandom_range(1, NBTN);
        for (k = 0; k < nb; k++) begin
          b = BTN_W'($urandom_range(0, NBTN - 1));
          picks.push_back(b);
          now_us += settle_gap();
          queue_req(REQ_EDGE, b, 1'b1, now_us);
          added++;
          if ($urandom_range(0, 99) < 30) begin
            queue_req(REQ_EDGE, b, 1'($urandom_range(0, 1)), now_us + bounce_gap());
            added++;
          end
        end
        pressed_at = now_us;
        if ($urandom_range(0, 3) != 0) begin
          if ($urandom_range(0, 1) == 1) begin
            queue_req(REQ_TICK, BTN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                      pressed_at + TIME_W'(hold_us) - 1);
            added++;
          end
          now_us = pressed_at + TIME_W'(hold_us);
          if ($urandom_range(0, 1) == 1) now_us += TIME_W'($urandom_range(1, 3000));
          queue_req(REQ_TICK, BTN_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), now_us);
          added++;
        end
        while (picks.size() != 0) begin
          k = $urandom_range(0, picks.size() - 1);
          b = picks[k];
          picks.delete(k);
          if ($urandom_range(0, 3) == 0) now_us += bounce_gap();
          else now_us += settle_gap();
          queue_req(REQ_EDGE, b, 1'b0, now_us);
          added++;
        end
      end
    end
  endtask

  // input side: a transfer hands the current item to the predictor
  always @(posedge clk) begin
    in_taken = !rst && s_axis_tvalid && s_axis_tready;
    if (in_taken) predict_events(cur_req);
  end

  always @(negedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || in_taken) begin
        if (button_reqs.size() != 0 && (no_stall || $urandom_range(0, 99) >= 7)) begin
          cur_req = button_reqs.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= S_TDATA_W'({cur_req.stamp, cur_req.press, cur_req.btn});
          s_axis_tuser  <= cur_req.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
    m_axis_tready <= no_stall || ($urandom_range(0, 99) >= 7);
  end

  always @(posedge clk) begin
    btn_event_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (due_events.size() == 0) begin
        $error("unexpected event: event_button %0d is_long %0b", m_axis_tdata[BTN_W-1:0],
               m_axis_tdata[BTN_W]);
        fails++;
      end else begin
        want = due_events.pop_front();
        if (m_axis_tdata[BTN_W-1:0] !== want.btn) begin
          $error("event_button: expected %0d, actual %0d", want.btn, m_axis_tdata[BTN_W-1:0]);
          fails++;
        end
        if (m_axis_tdata[BTN_W] !== want.is_long) begin
          $error("is_long: expected %0b, actual %0b", want.is_long, m_axis_tdata[BTN_W]);
          fails++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
          fails++;
        end
      end
    end
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int i;
    for (i = 0; i < NBTN; i++) begin
      held[i] = 1'b0;
      long_sent[i] = 1'b0;
      press_at[i] = '0;
      edge_at[i] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: only button 2 is long-press capable
    queue_req(REQ_EDGE, 2'd0, 1'b1, 32'd10);        // too close to time zero
    queue_req(REQ_EDGE, 2'd0, 1'b1, 32'd30000);
    queue_req(REQ_EDGE, 2'd0, 1'b1, 32'd60000);     // press while held
    queue_req(REQ_EDGE, 2'd0, 1'b0, 32'd70000);     // bounce
    queue_req(REQ_EDGE, 2'd0, 1'b0, 32'd95000);
    queue_req(REQ_EDGE, 2'd2, 1'b1, 32'd120000);
    queue_req(REQ_TICK, 2'd3, 1'b1, 32'd819999);    // one short of the hold time
    queue_req(REQ_TICK, 2'd0, 1'b0, 32'd820000);
    queue_req(REQ_TICK, 2'd1, 1'b1, 32'd900000);    // long already fired
    queue_req(REQ_EDGE, 2'd2, 1'b0, 32'd950000);
    queue_req(REQ_EDGE, 2'd2, 1'b1, 32'd1000000);
    queue_req(REQ_EDGE, 2'd2, 1'b0, 32'd1100000);
    queue_req(REQ_EDGE, 2'd3, 1'b0, 32'd1200000);   // release while not held
    queue_req(REQ_TICK, 2'd3, 1'b1, 32'hFFFF_FFFF);
    queue_req(REQ_EDGE, 2'd1, 1'b1, 32'hFFFF_FFFF);
    queue_req(REQ_EDGE, 2'd3, 1'b1, 32'h0000_1000); // gap across the wrap
    now_us = 32'h0001_0000;
    queue_gestures(15);
    wait_idle();

    // all buttons long-capable: four long events from one tick
    set_config('0, 24'd1000, 4'hF);
    for (i = 0; i < NBTN; i++) queue_req(REQ_EDGE, BTN_W'(i), 1'b0, now_us + 1 + i);
    for (i = 0; i < NBTN; i++) queue_req(REQ_EDGE, BTN_W'(i), 1'b1, now_us + 10 + i);
    now_us += 2000;
    queue_req(REQ_TICK, 2'd0, 1'b0, now_us);
    queue_gestures(15);
    wait_idle();

    no_stall = 1'b1;
    set_config('0, '0, 4'b0111);
    queue_gestures(15);
    wait_idle();
    no_stall = 1'b0;

    set_config('1, '1, '0);
    now_us = 32'hFFF0_0000;
    queue_gestures(15);
    wait_idle();

    set_config(DEB_W'($urandom_range(1, 400)), LONG_W'($urandom_range(500, 8000)),
               MASK_BITS'($urandom_range(0, 15)));
    queue_gestures(15);
    wait_idle();

    if (fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
